// File: sv/rqor_pkg.sv
package rqor_pkg;

  // configuration register width
  localparam int CFG_W = 9;

  // reset value of the ring size register
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // slot mark codes
  localparam int MARK_W = 2;
  localparam logic [MARK_W-1:0] MARK_EMPTY     = 2'd0;
  localparam logic [MARK_W-1:0] MARK_PROCESSED = 2'd1;
  localparam logic [MARK_W-1:0] MARK_FILLED    = 2'd2;

  // action codes
  localparam logic [1:0] ACT_PUSH     = 2'd0;
  localparam logic [1:0] ACT_CLAIM    = 2'd1;
  localparam logic [1:0] ACT_COMPLETE = 2'd2;
  localparam logic [1:0] ACT_POP      = 2'd3;

  // request item
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] request_count;
    logic [7:0] slot_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] granted_count;
    logic [7:0] batch_start;
  } out_item_t;

endpackage

// File: sv/ring_queue_with_ordered_retire.sv
// Ring of slot marks (empty, filled, processed) with four pointers that walk
// the ring in order: free, retire, claim, fill. Requests arrive as items on
// the in_ channel (valid/ready) and each gives exactly one item on the out_
// channel (valid/ready). Actions: push reserves slots at the fill pointer,
// claim hands out filled slots, complete marks any batch processed, pop
// retires processed slots and frees them. A zero count only queries, but a
// pop still retires processed slots first. Claim writes no marks; push and
// complete write one mark per slot of the batch, complete first reducing the
// slot index modulo the ring size, bit by bit, when it is not below it. Pop
// steps the retire pointer over processed slots, then writes one mark per
// freed slot. The mark memory has one write port, so slots are written one
// at a time; one item is in work at a time, and the next item is accepted
// while a result still waits.
// Reset and every ring size write zero the pointers and run a clearing pass
// over all n slots of the ring (256 after reset), while in_ready stays low.
// When the receiver stalls, the finished result holds in the output
// register and the block stops after accepting one more item.
module ring_queue_with_ordered_retire #(
  parameter int SLOTS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rqor_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rqor_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [rqor_pkg::CFG_W-1:0]    cfg_wdata
);

  import rqor_pkg::*;

  localparam int PW    = $clog2(SLOTS);
  localparam int NW    = $clog2(SLOTS + 1);
  localparam int CMP_W = (NW > CFG_W) ? NW : CFG_W;
  localparam int WW    = CMP_W + 1;

  localparam logic [WW-1:0] SLOTS_W = WW'(SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  // clamp the ring size to 2..SLOTS
  function automatic logic [WW-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [WW-1:0] x;
    x = WW'(v);
    if (x < WW'(2)) begin
      clamp_len = WW'(2);
    end else if (x > SLOTS_W) begin
      clamp_len = SLOTS_W;
    end else begin
      clamp_len = x;
    end
  endfunction

  // forward distance, both operands below n
  function automatic logic [WW-1:0] ring_dist(input logic [WW-1:0] from,
                                              input logic [WW-1:0] to,
                                              input logic [WW-1:0] n);
    ring_dist = (to >= from) ? (to - from) : (n + to - from);
  endfunction

  // a + b modulo n, with a + b below 2n
  function automatic logic [WW-1:0] wrap_add(input logic [WW-1:0] a,
                                             input logic [WW-1:0] b,
                                             input logic [WW-1:0] n);
    logic [WW-1:0] s;
    s = a + b;
    wrap_add = (s >= n) ? (s - n) : s;
  endfunction

  logic [2:0]        state_r,   state_nxt;
  logic [NW-1:0]     n_r,       n_nxt;
  logic [PW-1:0]     fill_r,    fill_nxt;
  logic [PW-1:0]     claim_r,   claim_nxt;
  logic [PW-1:0]     retire_r,  retire_nxt;
  logic [PW-1:0]     free_r,    free_nxt;
  logic [PW-1:0]     p_r,       p_nxt;
  logic [MARK_W-1:0] mark_r,    mark_nxt;
  logic [7:0]        cnt_r,     cnt_nxt;
  logic [7:0]        req_r,     req_nxt;
  logic [7:0]        idx_r,     idx_nxt;
  logic [7:0]        rem_r,     rem_nxt;
  logic [2:0]        bit_r,     bit_nxt;
  logic [7:0]        gr_r,      gr_nxt;
  logic [7:0]        start_r,   start_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r,  out_item_nxt;

  logic [WW-1:0]     nw, fill_w, claim_w, retire_w, free_w, p_w;
  logic [WW-1:0]     avail_push, avail_claim, avail_pop;
  logic [WW-1:0]     req_in, req_held, grant_push, grant_claim, grant_pop;
  logic [PW-1:0]     p_inc, retire_inc;
  logic [WW-1:0]     sh_w, rem_w;
  logic [MARK_W-1:0] rd_mark;
  logic              ram_we;

  assign nw       = WW'(n_r);
  assign fill_w   = WW'(fill_r);
  assign claim_w  = WW'(claim_r);
  assign retire_w = WW'(retire_r);
  assign free_w   = WW'(free_r);
  assign p_w      = WW'(p_r);

  // available counts for each action
  assign avail_push  = (free_w > fill_w) ? (free_w - fill_w - WW'(1))
                                         : (nw + free_w - fill_w - WW'(1));
  assign avail_claim = ring_dist(claim_w, fill_w, nw);
  assign avail_pop   = ring_dist(free_w, retire_w, nw);

  // requests clipped to what is available
  assign req_in      = WW'(in_item.request_count);
  assign req_held    = WW'(req_r);
  assign grant_push  = (req_in > avail_push) ? avail_push : req_in;
  assign grant_claim = (req_in > avail_claim) ? avail_claim : req_in;
  assign grant_pop   = (req_held > avail_pop) ? avail_pop : req_held;

  // pointer steps with wrap at n
  assign p_inc      = (p_w + WW'(1) == nw) ? '0 : p_r + PW'(1);
  assign retire_inc = (retire_w + WW'(1) == nw) ? '0 : retire_r + PW'(1);

  // one bit of the slot index reduction per cycle
  assign sh_w  = WW'({rem_r, idx_r[7]});
  assign rem_w = (sh_w >= nw) ? (sh_w - nw) : sh_w;

  assign ram_we = (state_r == ST_RUN) || (state_r == ST_CLR);

  // control and pointer update
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    fill_nxt      = fill_r;
    claim_nxt     = claim_r;
    retire_nxt    = retire_r;
    free_nxt      = free_r;
    p_nxt         = p_r;
    mark_nxt      = mark_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    gr_nxt        = gr_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          start_nxt = '0;
          unique case (in_item.action)
            ACT_PUSH: begin
              if (avail_push == '0 || req_in == '0) begin
                gr_nxt    = avail_push[7:0];
                state_nxt = ST_OUT;
              end else begin
                gr_nxt    = grant_push[7:0];
                cnt_nxt   = grant_push[7:0];
                p_nxt     = fill_r;
                mark_nxt  = MARK_FILLED;
                fill_nxt  = PW'(wrap_add(fill_w, grant_push, nw));
                state_nxt = ST_RUN;
              end
            end
            ACT_CLAIM: begin
              if (avail_claim == '0 || req_in == '0) begin
                gr_nxt = avail_claim[7:0];
              end else begin
                gr_nxt    = grant_claim[7:0];
                start_nxt = claim_w[7:0];
                claim_nxt = PW'(wrap_add(claim_w, grant_claim, nw));
              end
              state_nxt = ST_OUT;
            end
            ACT_COMPLETE: begin
              gr_nxt = in_item.request_count;
              if (in_item.request_count == 8'd0) begin
                state_nxt = ST_OUT;
              end else begin
                cnt_nxt  = in_item.request_count;
                mark_nxt = MARK_PROCESSED;
                if (WW'(in_item.slot_index) < nw) begin
                  p_nxt     = PW'(in_item.slot_index);
                  state_nxt = ST_RUN;
                end else begin
                  idx_nxt   = in_item.slot_index;
                  rem_nxt   = '0;
                  bit_nxt   = 3'd7;
                  state_nxt = ST_MOD;
                end
              end
            end
            ACT_POP: begin
              req_nxt   = in_item.request_count;
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MOD: begin
        rem_nxt = rem_w[7:0];
        idx_nxt = {idx_r[6:0], 1'b0};
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          p_nxt     = PW'(rem_w);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        p_nxt   = p_inc;
        cnt_nxt = cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN: begin
        // rd_mark holds the mark at the current retire pointer
        if (retire_r != claim_r && rd_mark == MARK_PROCESSED) begin
          retire_nxt = retire_inc;
        end else if (avail_pop == '0 || req_r == 8'd0) begin
          gr_nxt    = avail_pop[7:0];
          state_nxt = ST_OUT;
        end else begin
          gr_nxt    = grant_pop[7:0];
          cnt_nxt   = grant_pop[7:0];
          p_nxt     = free_r;
          mark_nxt  = MARK_EMPTY;
          free_nxt  = PW'(wrap_add(free_w, grant_pop, nw));
          state_nxt = ST_RUN;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt.granted_count = gr_r;
          out_item_nxt.batch_start   = start_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      ST_CLR: begin
        p_nxt = p_inc;
        if (p_w == nw - WW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // ring size write restarts the ring
    if (cfg_we) begin
      n_nxt      = NW'(clamp_len(cfg_wdata));
      fill_nxt   = '0;
      claim_nxt  = '0;
      retire_nxt = '0;
      free_nxt   = '0;
      p_nxt      = '0;
      mark_nxt   = MARK_EMPTY;
      state_nxt  = ST_CLR;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      n_r         <= NW'(clamp_len(CFG_RESET));
      fill_r      <= '0;
      claim_r     <= '0;
      retire_r    <= '0;
      free_r      <= '0;
      p_r         <= '0;
      mark_r      <= MARK_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      fill_r      <= fill_nxt;
      claim_r     <= claim_nxt;
      retire_r    <= retire_nxt;
      free_r      <= free_nxt;
      p_r         <= p_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    gr_r       <= gr_nxt;
    start_r    <= start_nxt;
    out_item_r <= out_item_nxt;
  end

  // slot mark memory, read ahead at the next retire pointer
  rqor_ram #(
    .WIDTH (MARK_W),
    .DEPTH (SLOTS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_r),
    .wdata (mark_r),
    .raddr (retire_nxt),
    .rdata (rd_mark)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sv/rqor_ram.sv
module rqor_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rqor_checker.sv
module rqor_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input rqor_pkg::out_item_t        out_item,
  input logic                       cfg_we
);

  import rqor_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken right after reset");

  // a ring size write starts the clearing pass
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("item taken right after ring size write");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken back to back");

endmodule

bind ring_queue_with_ordered_retire rqor_checker u_rqor_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_we    (cfg_we)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rqor_pkg::*;

  localparam int unsigned RING_SLOTS  = 256;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned HOLD_PHASE  = 1;
  localparam int unsigned PAUSE_PHASE = 2;
  localparam int unsigned QUIET_PHASE = 5;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned IDLE_PCT    = 6;
  localparam int unsigned CFG_SETTLE  = 8;
  localparam int unsigned END_SETTLE  = 600;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  // one line of the directed sequence: a ring size write or a request
  typedef struct packed {
    logic             is_size;
    logic [CFG_W-1:0] size_val;
    in_item_t         req;
    logic             fixed;
    out_item_t        want;
  } plan_row_t;

  // a claimed batch still waiting to be completed
  typedef struct {
    int unsigned first;
    int unsigned len;
  } batch_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // shadow ring state
  logic [CFG_W-1:0]  ring_size_q;
  int unsigned       fill_p;
  int unsigned       claim_p;
  int unsigned       retire_p;
  int unsigned       free_p;
  logic [MARK_W-1:0] slot_marks_q [RING_SLOTS];

  out_item_t   pending_grants [$];
  batch_t      open_batches [$];
  plan_row_t   plan [$];

  int unsigned mismatches;
  int unsigned grants_checked;
  int unsigned sizes_written;
  int unsigned action_tally [4];
  int unsigned cycle_count;
  int unsigned hold_left;
  logic        hold_taken;
  logic        steady;
  logic        hold_request;

  ring_queue_with_ordered_retire dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // effective ring length
  function automatic int unsigned ring_len();
    if (ring_size_q < 2) return 2;
    if (ring_size_q > RING_SLOTS) return RING_SLOTS;
    return ring_size_q;
  endfunction

  function automatic int unsigned fwd_dist(int unsigned from, int unsigned to, int unsigned n);
    return (to >= from) ? (to - from) : (n + to - from);
  endfunction

  function automatic void clear_ring();
    fill_p   = 0;
    claim_p  = 0;
    retire_p = 0;
    free_p   = 0;
    foreach (slot_marks_q[i]) slot_marks_q[i] = MARK_EMPTY;
  endfunction

  // write one mark over a run of slots, wrapping at the ring length
  function automatic void paint(int unsigned first, int unsigned len, logic [MARK_W-1:0] mark);
    int unsigned n;
    int unsigned p;
    n = ring_len();
    p = first % n;
    repeat (len) begin
      slot_marks_q[p] = mark;
      p = (p + 1 == n) ? 0 : p + 1;
    end
  endfunction

  // apply one request to the shadow ring and return the grant it gives
  function automatic out_item_t compute_grant(in_item_t req);
    int unsigned n;
    int unsigned cnt;
    int unsigned avail;
    out_item_t   res;
    n   = ring_len();
    cnt = req.request_count;
    res = '0;
    case (req.action)
      ACT_PUSH: begin
        avail = (free_p > fill_p) ? free_p - fill_p - 1 : n + free_p - fill_p - 1;
        if (avail == 0 || cnt == 0) begin
          res.granted_count = 8'(avail);
        end else begin
          if (cnt > avail) cnt = avail;
          paint(fill_p, cnt, MARK_FILLED);
          fill_p = (fill_p + cnt) % n;
          res.granted_count = 8'(cnt);
        end
      end
      ACT_CLAIM: begin
        avail = fwd_dist(claim_p, fill_p, n);
        if (avail == 0 || cnt == 0) begin
          res.granted_count = 8'(avail);
        end else begin
          if (cnt > avail) cnt = avail;
          res.batch_start   = 8'(claim_p);
          res.granted_count = 8'(cnt);
          claim_p = (claim_p + cnt) % n;
        end
      end
      ACT_COMPLETE: begin
        paint(req.slot_index, cnt, MARK_PROCESSED);
        res.granted_count = req.request_count;
      end
      default: begin
        // retire runs over processed slots but never passes the claim pointer
        while (retire_p != claim_p && slot_marks_q[retire_p] == MARK_PROCESSED)
          retire_p = (retire_p + 1 == n) ? 0 : retire_p + 1;
        avail = fwd_dist(free_p, retire_p, n);
        if (avail == 0 || cnt == 0) begin
          res.granted_count = 8'(avail);
        end else begin
          if (cnt > avail) cnt = avail;
          paint(free_p, cnt, MARK_EMPTY);
          free_p = (free_p + cnt) % n;
          res.granted_count = 8'(cnt);
        end
      end
    endcase
    return res;
  endfunction

  function automatic plan_row_t plan_op(logic [1:0] act, int unsigned cnt, int unsigned idx,
                                        logic fixed, int unsigned g, int unsigned s);
    plan_row_t r;
    r = '0;
    r.req.action        = act;
    r.req.request_count = 8'(cnt);
    r.req.slot_index    = 8'(idx);
    r.fixed             = fixed;
    r.want.granted_count = 8'(g);
    r.want.batch_start   = 8'(s);
    return r;
  endfunction

  function automatic plan_row_t plan_size(int unsigned val);
    plan_row_t r;
    r = '0;
    r.is_size  = 1'b1;
    r.size_val = CFG_W'(val);
    return r;
  endfunction

  // append one row to the directed sequence
  function automatic void queue_row(plan_row_t r);
    plan = {plan, r};
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at result %0d: %s got %0d expected %0d", grants_checked, what, got, want);
    mismatches++;
  endtask

  // compare one accepted result with the oldest expected grant
  task automatic check_grant(out_item_t got);
    out_item_t want;
    if (pending_grants.size() == 0) begin
      flag_mismatch("result with no request waiting, granted_count", got.granted_count, 0);
    end else begin
      want = pending_grants.pop_front();
      if (got.granted_count !== want.granted_count)
        flag_mismatch("granted_count", got.granted_count, want.granted_count);
      if (got.batch_start !== want.batch_start)
        flag_mismatch("batch_start", got.batch_start, want.batch_start);
    end
    grants_checked++;
  endtask

  // offer one item, with a random gap before it, and predict its grant
  task automatic send_request(in_item_t req, logic fixed, out_item_t want, output out_item_t pred);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    pred = compute_grant(req);
    pending_grants = {pending_grants, (fixed ? want : pred)};
    action_tally[req.action]++;
  endtask

  // stop offering and wait for every outstanding grant
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  task automatic write_ring_size(logic [CFG_W-1:0] val);
    drain_results();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_size_q = val;
    clear_ring();
    open_batches.delete();
    sizes_written++;
  endtask

  // mostly well-formed traffic: completes follow claimed batches, in any order
  task automatic pick_request(output in_item_t req);
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(99);
    req.slot_index    = 8'($urandom_range(255));
    req.request_count = (roll < 8)  ? 8'd0 :
                        (roll < 13) ? 8'($urandom_range(255, 128)) :
                                      8'($urandom_range(16, 1));
    roll = $urandom_range(99);
    if (roll < 30) begin
      req.action = ACT_PUSH;
    end else if (roll < 55) begin
      req.action = ACT_CLAIM;
    end else if (roll < 80) begin
      req.action = ACT_COMPLETE;
      if (open_batches.size() != 0 && $urandom_range(9) != 0) begin
        k = $urandom_range(open_batches.size() - 1);
        req.slot_index    = 8'(open_batches[k].first);
        req.request_count = 8'(open_batches[k].len);
        open_batches.delete(k);
      end
    end else begin
      req.action = ACT_POP;
    end
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_grant(out_item);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_grants.size());
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    in_item_t         req;
    out_item_t        pred;
    plan_row_t        row;
    batch_t           claimed;
    logic [CFG_W-1:0] phase_sizes [PHASES];

    mismatches     = 0;
    grants_checked = 0;
    sizes_written  = 0;
    foreach (action_tally[i]) action_tally[i] = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_item      <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    steady       <= 1'b0;
    hold_request <= 1'b0;
    ring_size_q = CFG_RESET;
    clear_ring();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full ring, empty ring, wrapped completes, clamped sizes
    queue_row(plan_op(ACT_PUSH,       0,   0, 1'b1, 255, 0));
    queue_row(plan_op(ACT_CLAIM,      0,   0, 1'b1,   0, 0));
    queue_row(plan_op(ACT_POP,        0,   0, 1'b1,   0, 0));
    queue_row(plan_op(ACT_PUSH,     255,   0, 1'b1, 255, 0));
    queue_row(plan_op(ACT_PUSH,       1,   0, 1'b1,   0, 0));
    queue_row(plan_op(ACT_CLAIM,    255,   0, 1'b1, 255, 0));
    queue_row(plan_op(ACT_CLAIM,      1,   0, 1'b1,   0, 0));
    queue_row(plan_op(ACT_COMPLETE,  10, 255, 1'b1,  10, 0));
    queue_row(plan_op(ACT_POP,        0,   0, 1'b0,   0, 0));
    queue_row(plan_op(ACT_COMPLETE,   0,   9, 1'b1,   0, 0));
    queue_row(plan_op(ACT_COMPLETE, 255, 200, 1'b1, 255, 0));
    queue_row(plan_op(ACT_POP,      255,   0, 1'b0,   0, 0));
    queue_row(plan_op(ACT_POP,        1,   0, 1'b0,   0, 0));
    // size below the minimum acts as two slots
    queue_row(plan_size(0));
    queue_row(plan_op(ACT_PUSH,       0,   0, 1'b1,   1, 0));
    queue_row(plan_op(ACT_PUSH,     255,   0, 1'b1,   1, 0));
    queue_row(plan_op(ACT_CLAIM,    255,   0, 1'b1,   1, 0));
    queue_row(plan_op(ACT_COMPLETE,   1, 255, 1'b1,   1, 0));
    queue_row(plan_op(ACT_POP,        0,   0, 1'b0,   0, 0));
    queue_row(plan_op(ACT_COMPLETE,   3,   0, 1'b1,   3, 0));
    queue_row(plan_op(ACT_POP,      255,   0, 1'b0,   0, 0));
    // size above the maximum acts as the full ring
    queue_row(plan_size(511));
    queue_row(plan_op(ACT_PUSH,       0,   0, 1'b1, 255, 0));
    queue_row(plan_op(ACT_PUSH,       7,   3, 1'b0,   0, 0));
    queue_row(plan_op(ACT_CLAIM,      5,   0, 1'b0,   0, 0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_size) write_ring_size(row.size_val);
      else send_request(row.req, row.fixed, row.want, pred);
    end

    // random phases, each with its own ring size
    phase_sizes[0] = 9'd2;
    phase_sizes[1] = 9'd256;
    phase_sizes[2] = 9'd3;
    phase_sizes[3] = 9'd0;
    phase_sizes[4] = 9'd511;
    phase_sizes[5] = 9'd17;
    phase_sizes[6] = 9'd1;
    phase_sizes[7] = 9'd64;
    phase_sizes[8] = CFG_W'($urandom_range(511, 2));
    phase_sizes[9] = 9'd255;

    for (int ph = 0; ph < PHASES; ph++) begin
      write_ring_size(phase_sizes[ph]);
      if (ph == QUIET_PHASE) steady <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == HOLD_PHASE && i == 40) hold_request <= 1'b1;
        if (ph == PAUSE_PHASE && i == 100) drain_results();
        pick_request(req);
        send_request(req, 1'b0, '0, pred);
        if (req.action == ACT_CLAIM && req.request_count != 0 && pred.granted_count != 0) begin
          claimed.first = pred.batch_start;
          claimed.len   = pred.granted_count;
          open_batches  = {open_batches, claimed};
        end
      end
      if (ph == QUIET_PHASE) steady <= 1'b0;
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);

    $display("run covered %0d requests: push %0d, claim %0d, complete %0d, pop %0d",
             action_tally[0] + action_tally[1] + action_tally[2] + action_tally[3],
             action_tally[ACT_PUSH], action_tally[ACT_CLAIM],
             action_tally[ACT_COMPLETE], action_tally[ACT_POP]);
    $display("%0d results checked over %0d ring size writes, %0d mismatches",
             grants_checked, sizes_written, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
